>>> design/bobc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bobc_pkg: shared types and constants for the bit offset block copy
// Memory geometry, operation codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package bobc_pkg;

  localparam int MEM_BYTES = 256;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int BIT_W     = ADDR_W + 3;
  localparam int CNT_W     = BIT_W + 1;
  localparam int SUM_W     = CNT_W + 1;
  localparam int BIT_LIMIT = MEM_BYTES * 8;
  localparam int DB_W      = 9;

  typedef enum logic [1:0] {
    OP_WRITE_SRC = 2'd0,
    OP_WRITE_DST = 2'd1,
    OP_READ_DST  = 2'd2,
    OP_COPY      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PRIME,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [7:0]         byte_index;
    logic [7:0]         byte_value;
    logic [BIT_W-1:0]   src_bit_offset;
    logic [BIT_W-1:0]   dst_bit_offset;
    logic [CNT_W-1:0]   bit_count;
  } in_item_t;

  typedef struct packed {
    logic               src_we;
    logic [ADDR_W-1:0]  src_waddr;
    logic [ADDR_W-1:0]  src_raddr;
    logic               dst_we_byte;
    logic               dst_we_merge;
    logic [ADDR_W-1:0]  dst_waddr;
    logic [ADDR_W-1:0]  dst_raddr;
    logic               lo_load;
    logic [7:0]         mask;
    logic [2:0]         shift;
  } mem_ctl_t;

  typedef struct packed {
    logic               load;
    logic               use_read;
    logic [DB_W-1:0]    dest_bytes;
    logic               range_error;
  } res_ctl_t;

endpackage

>>> design/bobc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bobc_if: request and response channels
// Valid/ready channels carrying copy requests and their responses.
// ----------------------------------------------------------------------------
interface bobc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  byte_index;
  logic [7:0]  byte_value;
  logic [10:0] src_bit_offset;
  logic [10:0] dst_bit_offset;
  logic [11:0] bit_count;

  modport source (output valid, output operation, output byte_index, output byte_value,
                  output src_bit_offset, output dst_bit_offset, output bit_count,
                  input ready);
  modport sink   (input valid, input operation, input byte_index, input byte_value,
                  input src_bit_offset, input dst_bit_offset, input bit_count,
                  output ready);
endinterface

interface bobc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic [8:0] dest_bytes;
  logic       range_error;

  modport source (output valid, output read_value, output dest_bytes, output range_error,
                  input ready);
  modport sink   (input valid, input read_value, input dest_bytes, input range_error,
                  output ready);
endinterface

>>> design/bobc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bobc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bobc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bobc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bobc_seq: operation sequencer
// Decodes requests and walks a copy one destination byte per cycle.
// ----------------------------------------------------------------------------
module bobc_seq
  import bobc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     out_free_i,
  output mem_ctl_t ctl_o,
  output res_ctl_t res_o
);

  state_e             state_q, state_d;
  logic               merge_q, merge_d;
  logic               src_ret_q, src_ret_d;
  logic               rd_ok_q, rd_ok_d;
  logic [ADDR_W-1:0]  j_q, j_d;
  logic [ADDR_W-1:0]  j0_q, j0_d;
  logic [ADDR_W-1:0]  jlast_q, jlast_d;
  logic [ADDR_W-1:0]  sa_q, sa_d;
  logic [ADDR_W-1:0]  wj_q, wj_d;
  logic [2:0]         sh_q, sh_d;
  logic [2:0]         lb_q, lb_d;
  logic [2:0]         ub_q, ub_d;
  logic [7:0]         mask_q, mask_d;
  logic [DB_W-1:0]    len_q, len_d;

  logic               in_fire;
  logic               idx_ok;
  logic [ADDR_W-1:0]  idx;
  logic [SUM_W-1:0]   src_end;
  logic [SUM_W-1:0]   dst_end;
  logic [SUM_W-1:0]   dst_last;
  logic [SUM_W:0]     len_full;
  logic [SUM_W-1:0]   src_base;
  logic               copy_err;
  logic               copy_empty;
  logic [2:0]         lo_bit;
  logic [2:0]         hi_bit;
  logic [7:0]         mask_now;

  assign in_ready_o = (state_q == ST_IDLE) && out_free_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign idx_ok     = (32'(in_item_i.byte_index) < MEM_BYTES);
  assign idx        = in_item_i.byte_index[ADDR_W-1:0];

  assign src_end  = SUM_W'(in_item_i.src_bit_offset) + SUM_W'(in_item_i.bit_count);
  assign dst_end  = SUM_W'(in_item_i.dst_bit_offset) + SUM_W'(in_item_i.bit_count);
  assign dst_last = dst_end - SUM_W'(1);
  assign len_full = (SUM_W+1)'(dst_end) + (SUM_W+1)'(7);
  // source bit that lines up with bit 0 of the first destination byte
  assign src_base = SUM_W'(in_item_i.src_bit_offset)
                  - SUM_W'(in_item_i.dst_bit_offset[2:0]);

  assign copy_err   = (src_end > SUM_W'(BIT_LIMIT)) || (dst_end > SUM_W'(BIT_LIMIT));
  assign copy_empty = (in_item_i.bit_count == '0);

  assign lo_bit   = (j_q == j0_q)    ? lb_q : 3'd0;
  assign hi_bit   = (j_q == jlast_q) ? ub_q : 3'd7;
  assign mask_now = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      merge_q   <= 1'b0;
      src_ret_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      merge_q   <= merge_d;
      src_ret_q <= src_ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q <= rd_ok_d;
    j_q     <= j_d;
    j0_q    <= j0_d;
    jlast_q <= jlast_d;
    sa_q    <= sa_d;
    wj_q    <= wj_d;
    sh_q    <= sh_d;
    lb_q    <= lb_d;
    ub_q    <= ub_d;
    mask_q  <= mask_d;
    len_q   <= len_d;
  end

  always_comb begin
    state_d   = state_q;
    rd_ok_d   = rd_ok_q;
    j_d       = j_q;
    j0_d      = j0_q;
    jlast_d   = jlast_q;
    sa_d      = sa_q;
    wj_d      = wj_q;
    sh_d      = sh_q;
    lb_d      = lb_q;
    ub_d      = ub_q;
    mask_d    = mask_q;
    len_d     = len_q;
    merge_d   = (state_q == ST_RUN);
    src_ret_d = (state_q == ST_PRIME) || (state_q == ST_RUN);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item_i.operation)
            OP_READ_DST: begin
              state_d = ST_READ;
              rd_ok_d = idx_ok;
            end
            OP_COPY: begin
              if (!copy_err && !copy_empty) begin
                state_d = ST_PRIME;
                j_d     = in_item_i.dst_bit_offset[BIT_W-1:3];
                j0_d    = in_item_i.dst_bit_offset[BIT_W-1:3];
                lb_d    = in_item_i.dst_bit_offset[2:0];
                jlast_d = dst_last[BIT_W-1:3];
                ub_d    = dst_last[2:0];
                sa_d    = src_base[BIT_W-1:3];
                sh_d    = src_base[2:0];
                len_d   = len_full[DB_W+2:3];
              end
            end
            OP_WRITE_SRC, OP_WRITE_DST: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_PRIME: begin
        sa_d    = sa_q + ADDR_W'(1);
        state_d = ST_RUN;
      end
      ST_RUN: begin
        sa_d   = sa_q + ADDR_W'(1);
        j_d    = j_q + ADDR_W'(1);
        wj_d   = j_q;
        mask_d = mask_now;
        if (j_q == jlast_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o              = '0;
    res_o              = '0;
    ctl_o.src_waddr    = idx;
    ctl_o.src_raddr    = sa_q;
    ctl_o.dst_raddr    = (state_q == ST_IDLE) ? idx : j_q;
    ctl_o.dst_waddr    = merge_q ? wj_q : idx;
    ctl_o.dst_we_merge = merge_q;
    ctl_o.lo_load      = src_ret_q;
    ctl_o.mask         = mask_q;
    ctl_o.shift        = sh_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item_i.operation)
            OP_WRITE_SRC: begin
              ctl_o.src_we = idx_ok;
              res_o.load   = 1'b1;
            end
            OP_WRITE_DST: begin
              ctl_o.dst_we_byte = idx_ok;
              res_o.load        = 1'b1;
            end
            OP_COPY: begin
              if (copy_err) begin
                res_o.load        = 1'b1;
                res_o.range_error = 1'b1;
              end else if (copy_empty) begin
                res_o.load       = 1'b1;
                res_o.dest_bytes = len_full[DB_W+2:3];
              end
            end
            OP_READ_DST: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_o.load     = 1'b1;
        res_o.use_read = rd_ok_q;
      end
      ST_DRAIN: begin
        res_o.load       = 1'b1;
        res_o.dest_bytes = len_q;
      end
      ST_PRIME, ST_RUN: begin
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/bit_offset_block_copy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_offset_block_copy: bit granular copy between two byte memories
// Source and destination byte RAMs, copy merge datapath, response register.
// ----------------------------------------------------------------------------
// Byte writes, rejected copies and empty copies answer at the transfer edge;
// a destination read answers in the cycle after its transfer. A copy spanning
// N destination bytes answers from the drain state. The prime state primes the
// source window, then in the run state each cycle one destination byte is
// read, merged with a shifted window of two source bytes and written back,
// limited by the single read and write port of each RAM. A new request
// transfers only when the response register is empty or its response
// transfers in the same cycle.
module bit_offset_block_copy
  import bobc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bobc_in_if.sink    in_ch,
  bobc_out_if.source out_ch
);

  in_item_t    in_item;
  mem_ctl_t    ctl;
  res_ctl_t    res;
  logic        out_free;
  logic [7:0]  src_rdata;
  logic [7:0]  dst_rdata;
  logic [7:0]  dst_wdata;
  logic [15:0] window;
  logic [15:0] window_sh;
  logic [7:0]  merged;
  logic [7:0]  lo_q;
  logic        out_valid_q;
  logic [7:0]  read_value_q;
  logic [8:0]  dest_bytes_q;
  logic        range_error_q;

  assign in_item.operation      = op_e'(in_ch.operation);
  assign in_item.byte_index     = in_ch.byte_index;
  assign in_item.byte_value     = in_ch.byte_value;
  assign in_item.src_bit_offset = in_ch.src_bit_offset;
  assign in_item.dst_bit_offset = in_ch.dst_bit_offset;
  assign in_item.bit_count      = in_ch.bit_count;

  assign out_free = !out_valid_q || out_ch.ready;

  bobc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .in_item_i  (in_item),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .res_o      (res)
  );

  bobc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.src_we),
    .waddr_i (ctl.src_waddr),
    .wdata_i (in_ch.byte_value),
    .raddr_i (ctl.src_raddr),
    .rdata_o (src_rdata)
  );

  bobc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dst_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.dst_we_byte || ctl.dst_we_merge),
    .waddr_i (ctl.dst_waddr),
    .wdata_i (dst_wdata),
    .raddr_i (ctl.dst_raddr),
    .rdata_o (dst_rdata)
  );

  // previous source byte is the low half of the window
  assign window    = {src_rdata, lo_q};
  assign window_sh = window >> ctl.shift;
  assign merged    = (dst_rdata & ~ctl.mask) | (window_sh[7:0] & ctl.mask);
  assign dst_wdata = ctl.dst_we_merge ? merged : in_ch.byte_value;

  always_ff @(posedge clk_i) begin
    if (ctl.lo_load) begin
      lo_q <= src_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      read_value_q  <= res.use_read ? dst_rdata : 8'd0;
      dest_bytes_q  <= res.dest_bytes;
      range_error_q <= res.range_error;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.read_value  = read_value_q;
  assign out_ch.dest_bytes  = dest_bytes_q;
  assign out_ch.range_error = range_error_q;

endmodule

>>> tb/sv/bit_offset_block_copy_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_offset_block_copy_tb: self-checking bench for the bit offset block copy
// Fills both byte memories, runs directed corner copies, then random byte
// writes, reads and copies with random stalls on both channels. Each response
// is checked field by field against a bit-level model of both memories.
// ----------------------------------------------------------------------------
module bit_offset_block_copy_tb;
  import bobc_pkg::*;

  typedef struct packed {
    logic [7:0]      read_value;
    logic [DB_W-1:0] dest_bytes;
    logic            range_error;
  } copy_result_t;

  class copy_board;
    logic [7:0]   src_mem [MEM_BYTES];
    logic [7:0]   dst_mem [MEM_BYTES];
    copy_result_t pending_results [$];
    int           errors;
    int           n_writes;
    int           n_reads;
    int           n_copies;
    int           n_rejected;

    task report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("mismatch %0d: %s expected %0h got %0h", errors, what, want, got);
    endtask

    function void note_request(in_item_t r);
      copy_result_t res;
      int unsigned  src;
      int unsigned  dst;
      int unsigned  cnt;
      int unsigned  len;
      int unsigned  s;
      int unsigned  d;
      int unsigned  k;
      res = '0;
      src = 32'(r.src_bit_offset);
      dst = 32'(r.dst_bit_offset);
      cnt = 32'(r.bit_count);
      case (r.operation)
        OP_WRITE_SRC: begin
          src_mem[r.byte_index] = r.byte_value;
          n_writes++;
        end
        OP_WRITE_DST: begin
          dst_mem[r.byte_index] = r.byte_value;
          n_writes++;
        end
        OP_READ_DST: begin
          res.read_value = dst_mem[r.byte_index];
          n_reads++;
        end
        default: begin
          n_copies++;
          if (src + cnt > BIT_LIMIT || dst + cnt > BIT_LIMIT) begin
            res.range_error = 1'b1;
            n_rejected++;
          end else begin
            for (k = 0; k < cnt; k++) begin
              s = src + k;
              d = dst + k;
              dst_mem[d[BIT_W-1:3]][d[2:0]] = src_mem[s[BIT_W-1:3]][s[2:0]];
            end
            len = (cnt + dst + 7) >> 3;
            if (len > 511) len = 511;
            res.dest_bytes = len[DB_W-1:0];
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    task check_response(copy_result_t got);
      copy_result_t want;
      if (pending_results.size() == 0) begin
        report("response with nothing pending", 0, 32'(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value)
        report("read_value", 32'(want.read_value), 32'(got.read_value));
      if (got.dest_bytes !== want.dest_bytes)
        report("dest_bytes", 32'(want.dest_bytes), 32'(got.dest_bytes));
      if (got.range_error !== want.range_error)
        report("range_error", 32'(want.range_error), 32'(got.range_error));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       calm;
  copy_board  board = new;

  bobc_in_if  in_ch ();
  bobc_out_if out_ch ();

  bit_offset_block_copy i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // response side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready)
      board.check_response({out_ch.read_value, out_ch.dest_bytes, out_ch.range_error});
  end

  function automatic in_item_t byte_op(op_e op, int unsigned idx, int unsigned val);
    in_item_t r;
    r.operation      = op;
    r.byte_index     = idx[7:0];
    r.byte_value     = val[7:0];
    r.src_bit_offset = BIT_W'($urandom_range(2047));
    r.dst_bit_offset = BIT_W'($urandom_range(2047));
    r.bit_count      = CNT_W'($urandom_range(4095));
    return r;
  endfunction

  function automatic in_item_t copy_op(int unsigned src, int unsigned dst, int unsigned cnt);
    in_item_t r;
    r.operation      = OP_COPY;
    r.byte_index     = 8'($urandom_range(255));
    r.byte_value     = 8'($urandom_range(255));
    r.src_bit_offset = src[BIT_W-1:0];
    r.dst_bit_offset = dst[BIT_W-1:0];
    r.bit_count      = cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic in_item_t random_item();
    int unsigned p;
    int unsigned q;
    int unsigned cnt;
    int unsigned src;
    int unsigned dst;
    p = $urandom_range(99);
    if (p < 22) return byte_op(OP_WRITE_SRC, $urandom_range(255), $urandom_range(255));
    if (p < 40) return byte_op(OP_WRITE_DST, $urandom_range(255), $urandom_range(255));
    if (p < 65) return byte_op(OP_READ_DST, $urandom_range(255), $urandom_range(255));
    q = $urandom_range(99);
    if (q < 80) begin
      if (q < 60)      cnt = $urandom_range(64);
      else if (q < 75) cnt = $urandom_range(512, 65);
      else             cnt = $urandom_range(2048, 513);
      src = $urandom_range(2048 - cnt);
      dst = $urandom_range(2048 - cnt);
    end else if (q < 90) begin
      // one bit past the end of one memory
      cnt = $urandom_range(512, 2);
      if ($urandom_range(1)) begin
        src = 2049 - cnt;
        dst = $urandom_range(2048 - cnt);
      end else begin
        src = $urandom_range(2048 - cnt);
        dst = 2049 - cnt;
      end
    end else begin
      src = $urandom_range(2047);
      dst = $urandom_range(2047);
      cnt = $urandom_range(4095);
    end
    return copy_op(src, dst, cnt);
  endfunction

  task automatic push_request(in_item_t r);
    while (!calm && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= r.operation;
    in_ch.byte_index     <= r.byte_index;
    in_ch.byte_value     <= r.byte_value;
    in_ch.src_bit_offset <= r.src_bit_offset;
    in_ch.dst_bit_offset <= r.dst_bit_offset;
    in_ch.bit_count      <= r.bit_count;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  initial begin
    int i;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OP_WRITE_SRC;
    in_ch.byte_index     = '0;
    in_ch.byte_value     = '0;
    in_ch.src_bit_offset = '0;
    in_ch.dst_bit_offset = '0;
    in_ch.bit_count      = '0;
    calm   = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // both memories fully written first
    for (i = 0; i < MEM_BYTES; i++)
      push_request(byte_op(OP_WRITE_SRC, i, $urandom_range(255)));
    for (i = 0; i < MEM_BYTES; i++)
      push_request(byte_op(OP_WRITE_DST, i, $urandom_range(255)));

    push_request(byte_op(OP_WRITE_SRC, 0, 255));
    push_request(byte_op(OP_WRITE_SRC, 255, 0));
    push_request(byte_op(OP_WRITE_DST, 0, 0));
    push_request(byte_op(OP_WRITE_DST, 255, 255));
    push_request(byte_op(OP_READ_DST, 0, 0));
    push_request(byte_op(OP_READ_DST, 255, 0));
    push_request(copy_op(0, 0, 2048));
    push_request(byte_op(OP_READ_DST, 128, 0));
    push_request(copy_op(0, 0, 0));
    push_request(copy_op(0, 2047, 0));
    push_request(copy_op(2047, 5, 0));
    push_request(copy_op(2047, 0, 1));
    push_request(copy_op(0, 2047, 1));
    push_request(byte_op(OP_READ_DST, 255, 0));
    push_request(copy_op(1, 0, 2048));
    push_request(copy_op(0, 1, 2048));
    push_request(copy_op(2047, 2047, 4095));
    push_request(copy_op(3, 13, 7));
    push_request(copy_op(5, 250, 20));
    push_request(byte_op(OP_READ_DST, 1, 0));
    push_request(byte_op(OP_READ_DST, 31, 0));
    push_request(byte_op(OP_READ_DST, 32, 0));

    for (i = 0; i < 800; i++) begin
      calm = (i >= 200 && i < 350);
      push_request(random_item());
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (board.pending_results.size() != 0)
      board.report("responses still pending", 0, board.pending_results.size());

    $display("covered %0d byte writes, %0d reads, %0d copies (%0d out of range)",
             board.n_writes, board.n_reads, board.n_copies, board.n_rejected);
    $display("with random stalls on both channels and %0d mismatches", board.errors);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
